FILE: rtl/drc_pkg.sv
package drc_pkg;

	// field widths
	localparam int ADDR_W = 14;
	localparam int COL_W  = 6;
	localparam int ROW_W  = 8;
	localparam int LEFT_W = 9;
	localparam int TOP_W  = 8;
	localparam int DIM_W  = 7;
	localparam int W_W    = 10;
	localparam int H_W    = 9;

	// display geometry
	localparam int SCREEN_WIDTH  = 384;
	localparam int SCREEN_HEIGHT = 256;
	localparam int TILE_SIZE     = 64;

	// box limits, spans are max minus min
	localparam int MAX_COL_SPAN = 7;
	localparam int MAX_ROW_SPAN = 63;
	localparam int COL_SHIFT    = 3;

	// per-request output cap
	localparam int MAX_RESULTS = 24;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	// request kinds
	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_REFRESH = 2'd1,
		REQ_IDLE    = 2'd2
	} req_t;

	// area to be cut into tiles
	typedef struct packed {
		logic [LEFT_W-1:0] left;
		logic [TOP_W-1:0]  top;
		logic [W_W-1:0]    width;
		logic [H_W-1:0]    height;
	} area_t;

	// up to two areas caused by one request
	typedef struct packed {
		logic  a0_valid;
		area_t a0;
		logic  a1_valid;
		area_t a1;
	} work_t;

	// one output rectangle
	typedef struct packed {
		logic [DIM_W-1:0]  height;
		logic [DIM_W-1:0]  width;
		logic [TOP_W-1:0]  top;
		logic [LEFT_W-1:0] left;
	} rect_t;

endpackage

FILE: rtl/drc_box.sv
module drc_box (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  drc_pkg::req_t                 req,
	input  logic [drc_pkg::ADDR_W-1:0]    addr,
	input  logic                          word_access,
	output drc_pkg::work_t                work
);
	import drc_pkg::*;

	typedef struct packed {
		logic             empty;
		logic [COL_W-1:0] min_col;
		logic [COL_W-1:0] max_col;
		logic [ROW_W-1:0] min_row;
		logic [ROW_W-1:0] max_row;
	} box_t;

	typedef struct packed {
		box_t  box;
		logic  flush;
		area_t area;
	} absorb_t;

	box_t box_q;
	box_t box_d;

	// pending box as a pixel area
	function automatic area_t box_area(input box_t b);
		area_t a;
		a.left   = LEFT_W'({b.min_col, 3'b000});
		a.top    = b.min_row;
		a.width  = (W_W'(b.max_col - b.min_col) + W_W'(1)) << COL_SHIFT;
		a.height = H_W'(b.max_row - b.min_row) + H_W'(1);
		return a;
	endfunction

	// add one address to the box, flushing when the span grows too large
	function automatic absorb_t absorb(input box_t b, input logic [ADDR_W-1:0] a);
		absorb_t          r;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] lo_c;
		logic [COL_W-1:0] hi_c;
		logic [ROW_W-1:0] lo_r;
		logic [ROW_W-1:0] hi_r;
		col  = a[ADDR_W-1:ROW_W];
		row  = a[ROW_W-1:0];
		lo_c = (col < b.min_col) ? col : b.min_col;
		hi_c = (col > b.max_col) ? col : b.max_col;
		lo_r = (row < b.min_row) ? row : b.min_row;
		hi_r = (row > b.max_row) ? row : b.max_row;
		r.area  = box_area(b);
		r.flush = 1'b0;
		r.box   = '{empty: 1'b0, min_col: col, max_col: col, min_row: row, max_row: row};
		if (!b.empty) begin
			if ((hi_c - lo_c) > COL_W'(MAX_COL_SPAN) || (hi_r - lo_r) > ROW_W'(MAX_ROW_SPAN)) begin
				r.flush = 1'b1;
			end else begin
				r.box = '{empty: 1'b0, min_col: lo_c, max_col: hi_c,
					min_row: lo_r, max_row: hi_r};
			end
		end
		return r;
	endfunction

	absorb_t           r_first;
	absorb_t           r_second;
	logic [ADDR_W-1:0] addr_next;

	assign addr_next = addr + ADDR_W'(1);
	assign r_first   = absorb(box_q, addr);
	assign r_second  = absorb(r_first.box, addr_next);

	// areas and next box for the current request
	always_comb begin
		box_d         = box_q;
		work.a0_valid = 1'b0;
		work.a0       = box_area(box_q);
		work.a1_valid = 1'b0;
		work.a1       = r_second.area;
		case (req)
			REQ_WRITE: begin
				box_d = word_access ? r_second.box : r_first.box;
				if (r_first.flush) begin
					work.a0_valid = 1'b1;
					work.a0       = r_first.area;
					work.a1_valid = word_access && r_second.flush;
				end else begin
					work.a0_valid = word_access && r_second.flush;
					work.a0       = r_second.area;
				end
			end
			REQ_REFRESH: begin
				box_d.empty   = 1'b1;
				work.a0_valid = 1'b1;
				work.a0       = '{left: '0, top: '0, width: W_W'(SCREEN_WIDTH),
					height: H_W'(SCREEN_HEIGHT)};
			end
			REQ_IDLE: begin
				box_d.empty   = 1'b1;
				work.a0_valid = !box_q.empty;
			end
			default: begin
				box_d = box_q;
			end
		endcase
	end

	// box state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '{empty: 1'b1, default: '0};
		end else if (take) begin
			box_q <= box_d;
		end
	end

endmodule

FILE: rtl/drc_tiler.sv
module drc_tiler (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  drc_pkg::work_t work,
	output logic           free,
	input  logic           m_tready,
	output logic           m_tvalid,
	output drc_pkg::rect_t rect,
	output logic           m_tlast
);
	import drc_pkg::*;

	logic             busy_q;
	logic [W_W-1:0]   cx_q;
	logic [H_W-1:0]   cy_q;
	logic [W_W-1:0]   rw_q;
	logic [H_W-1:0]   rh_q;
	logic [TOP_W-1:0] top_q;
	logic [H_W-1:0]   ht_q;
	logic             pend_vld_q;
	area_t            pend_q;
	logic [CNT_W-1:0] cnt_q;
	logic             m_tvalid_q;
	rect_t            rect_q;
	logic             last_q;

	logic [W_W-1:0] dw;
	logic [H_W-1:0] dh;
	logic           more_rows;
	logic           more_cols;
	logic           cap_hit;
	logic           item_end;
	logic           step;

	// current tile size and walk position
	assign dw        = (rw_q < W_W'(TILE_SIZE)) ? rw_q : W_W'(TILE_SIZE);
	assign dh        = (rh_q < H_W'(TILE_SIZE)) ? rh_q : H_W'(TILE_SIZE);
	assign more_rows = rh_q > dh;
	assign more_cols = rw_q > dw;
	assign cap_hit   = cnt_q == CNT_W'(MAX_RESULTS - 1);
	assign item_end  = cap_hit || (!more_rows && !more_cols && !pend_vld_q);
	assign step      = busy_q && (!m_tvalid_q || m_tready);
	assign free      = !busy_q || (step && item_end);

	// tile walker, column-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
		end else if (take) begin
			busy_q     <= work.a0_valid;
			pend_vld_q <= work.a1_valid;
			cnt_q      <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (item_end) begin
				busy_q <= 1'b0;
			end else if (!more_rows && !more_cols) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	// walker payload
	always_ff @(posedge clk) begin
		if (take) begin
			cx_q   <= W_W'(work.a0.left);
			cy_q   <= H_W'(work.a0.top);
			rw_q   <= work.a0.width;
			rh_q   <= work.a0.height;
			top_q  <= work.a0.top;
			ht_q   <= work.a0.height;
			pend_q <= work.a1;
		end else if (step) begin
			if (more_rows) begin
				cy_q <= cy_q + dh;
				rh_q <= rh_q - dh;
			end else if (more_cols) begin
				cx_q <= cx_q + dw;
				rw_q <= rw_q - dw;
				cy_q <= H_W'(top_q);
				rh_q <= ht_q;
			end else begin
				cx_q  <= W_W'(pend_q.left);
				cy_q  <= H_W'(pend_q.top);
				rw_q  <= pend_q.width;
				rh_q  <= pend_q.height;
				top_q <= pend_q.top;
				ht_q  <= pend_q.height;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rect_q.left   <= cx_q[LEFT_W-1:0];
			rect_q.top    <= cy_q[TOP_W-1:0];
			rect_q.width  <= dw[DIM_W-1:0];
			rect_q.height <= dh[DIM_W-1:0];
			last_q        <= item_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign rect     = rect_q;
	assign m_tlast  = last_q;

`ifndef ASSERT_OFF
	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> free)
		else $error("request taken while walker still has work");

	a_rect_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (rect.width != '0 && rect.width <= DIM_W'(TILE_SIZE)
			&& rect.height != '0 && rect.height <= DIM_W'(TILE_SIZE)))
		else $error("rectangle size out of tile range");

	a_walk_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rw_q != '0 && rh_q != '0))
		else $error("walker busy on empty area");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= CNT_W'(MAX_RESULTS - 1)))
		else $error("rectangle count past cap");
`endif

endmodule

FILE: rtl/dirty_rectangle_coalescer_unit.sv
// channel  | dir | tdata (low bit up)                           | tuser    | tlast
// s_       | in  | addr[13:0], word_access[14], zero pad [15]    | req_type | -
// m_       | out | rect_left[8:0], rect_top[16:9],               | -        | last
//          |     | rect_width[23:17], rect_height[30:24], pad   |          |
//
// a request waits in the input register, then box update and area setup load the
// tile walker, which loads one rectangle a cycle into the output register unless
// the output stalls; writes that flush nothing go through at one per cycle while
// the walker is idle; a request that emits n rectangles holds the next one until
// the tile walker frees up (24 rectangles for a full refresh at 384x256)
// reset clears the box to empty and drops all requests in flight
// a stalled output holds the walker, which in turn holds the input register
module dirty_rectangle_coalescer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // addr, word_access
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // rect_left, rect_top, rect_width, rect_height
	output logic        m_tlast
);
	import drc_pkg::*;

	logic              valid_s1;
	req_t              req_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              word_s1;

	logic  take;
	logic  free;
	work_t work;
	rect_t rect;

	assign take     = valid_s1 && free;
	assign s_tready = !valid_s1 || take;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= req_t'(s_tuser);
			addr_s1 <= s_tdata[ADDR_W-1:0];
			word_s1 <= s_tdata[ADDR_W];
		end
	end

	drc_box u_box (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.req         (req_s1),
		.addr        (addr_s1),
		.word_access (word_s1),
		.work        (work)
	);

	drc_tiler u_tiler (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.work     (work),
		.free     (free),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.rect     (rect),
		.m_tlast  (m_tlast)
	);

	// pack result fields
	assign m_tdata = {1'b0, rect.height, rect.width, rect.top, rect.left};

endmodule
